FILE: rtl/sbe_pkg.sv
package sbe_pkg;

  // Defaults for the top-level parameters
  localparam int STACK_DEPTH_DEF = 1024;
  localparam int DATA_WIDTH_DEF  = 32;

  // Fixed field widths of the channels
  localparam int FUNC_W   = 3;
  localparam int PUSH_W   = 32;
  localparam int TOP_W    = 32;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ADD  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SUB  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MUL  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DIV  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PUSH = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RET  = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_ITER,
    S_WRITE,
    S_PUT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic start_iter;
    logic iter_step;
    logic commit;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic fault;
    logic op_direct;
    logic op_iter;
    logic iter_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/sbe_ctrl.sv
module sbe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sbe_pkg::sts_t sts,
  output sbe_pkg::cmd_t cmd
);

  sbe_pkg::state_t state_r;
  sbe_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbe_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_stall       = 1'b1;
    unique case (state_r)
      sbe_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sbe_pkg::S_DEC;
        end
      end
      sbe_pkg::S_DEC: begin
        if (sts.fault) begin
          state_nxt = sbe_pkg::S_PUT;
        end else if (sts.op_direct) begin
          state_nxt = sbe_pkg::S_WRITE;
        end else if (sts.op_iter) begin
          cmd.start_iter = 1'b1;
          state_nxt      = sbe_pkg::S_ITER;
        end else begin
          state_nxt = sbe_pkg::S_PUT;
        end
      end
      sbe_pkg::S_ITER: begin
        cmd.iter_step = 1'b1;
        if (sts.iter_last) begin
          state_nxt = sbe_pkg::S_WRITE;
        end
      end
      sbe_pkg::S_WRITE: begin
        cmd.commit = 1'b1;
        state_nxt  = sbe_pkg::S_PUT;
      end
      sbe_pkg::S_PUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sbe_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sbe_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/sbe_datapath.sv
module sbe_datapath #(
  parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = sbe_pkg::DATA_WIDTH_DEF,
  localparam int SPW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sbe_pkg::cmd_t                       cmd,
  output sbe_pkg::sts_t                       sts,
  input  logic [sbe_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [sbe_pkg::PUSH_W-1:0]   in_push_value,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [sbe_pkg::TOP_W-1:0]    out_top_value,
  output logic [SPW-1:0]                      out_depth,
  output logic [sbe_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_done_res
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH);

  // Stack memory and its registered read port
  logic [DW-1:0] mem [STACK_DEPTH];
  logic [DW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  // Architectural state
  logic [SPW-1:0] sp_r;
  logic [DW-1:0]  top_r;

  // Captured item
  logic [sbe_pkg::FUNC_W-1:0]   func_r;
  logic [DW-1:0]                pv_r;
  logic [sbe_pkg::STATUS_W-1:0] status_r;
  logic [sbe_pkg::STATUS_W-1:0] status_new;

  // Shared multiply and divide unit
  logic [DW-1:0]   x_r;
  logic [DW-1:0]   y_r;
  logic [DW:0]     z_r;
  logic [CW-1:0]   cnt_r;
  logic            neg_r;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic [DW-1:0]   abs_a;
  logic [DW-1:0]   abs_b;
  logic [DW-1:0]   quot;
  logic [DW-1:0]   result;

  // Output register
  logic                           out_valid_r;
  logic [DW-1:0]                  top_show;
  logic signed [sbe_pkg::TOP_W-1:0] out_top_r;
  logic [SPW-1:0]                 out_depth_r;
  logic [sbe_pkg::STATUS_W-1:0]   out_status_r;
  logic                           out_done_r;

  // Classify the incoming item against the current stack
  always_comb begin
    status_new = sbe_pkg::ST_OK;
    if (in_func <= sbe_pkg::FN_DIV) begin
      if (sp_r < SPW'(2)) begin
        status_new = sbe_pkg::ST_UNDER;
      end else if (in_func == sbe_pkg::FN_DIV && top_r == '0) begin
        status_new = sbe_pkg::ST_DIVZ;
      end
    end else if (in_func == sbe_pkg::FN_PUSH && sp_r == SPW'(STACK_DEPTH)) begin
      status_new = sbe_pkg::ST_OVER;
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      pv_r     <= DW'(in_push_value);
      status_r <= status_new;
    end
  end

  // Magnitudes of the operands for division
  assign abs_a = rd_data_r[DW-1] ? (~rd_data_r) + DW'(1) : rd_data_r;
  assign abs_b = top_r[DW-1] ? (~top_r) + DW'(1) : top_r;

  // One restoring division step
  assign trial = {z_r[DW-1:0], x_r[DW-1]};
  assign diff  = trial - {1'b0, y_r};

  // Run the shared unit one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.start_iter) begin
      cnt_r <= CW'(DATA_WIDTH - 1);
      z_r   <= '0;
      neg_r <= rd_data_r[DW-1] ^ top_r[DW-1];
      if (func_r == sbe_pkg::FN_MUL) begin
        x_r <= rd_data_r;
        y_r <= top_r;
      end else begin
        x_r <= abs_a;
        y_r <= abs_b;
      end
    end else if (cmd.iter_step) begin
      cnt_r <= cnt_r - CW'(1);
      if (func_r == sbe_pkg::FN_MUL) begin
        if (x_r[0]) begin
          z_r <= z_r + {1'b0, y_r};
        end
        x_r <= x_r >> 1;
        y_r <= y_r << 1;
      end else begin
        z_r <= diff[DW] ? trial : diff;
        x_r <= {x_r[DW-2:0], ~diff[DW]};
      end
    end
  end

  assign quot = neg_r ? (~x_r) + DW'(1) : x_r;

  // Select the arithmetic result
  always_comb begin
    case (func_r)
      sbe_pkg::FN_ADD: result = rd_data_r + top_r;
      sbe_pkg::FN_SUB: result = rd_data_r - top_r;
      sbe_pkg::FN_MUL: result = z_r[DW-1:0];
      sbe_pkg::FN_DIV: result = quot;
      default:         result = pv_r;
    endcase
  end

  // Memory addresses: second entry for reads, push slot or second entry for writes
  assign rd_addr = AW'(sp_r - SPW'(2));
  assign wr_addr = (func_r == sbe_pkg::FN_PUSH) ? AW'(sp_r) : rd_addr;
  assign wr_data = result;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Advance the stack pointer and the cached top entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.commit) begin
      if (func_r == sbe_pkg::FN_PUSH) begin
        sp_r <= sp_r + SPW'(1);
      end else begin
        sp_r <= sp_r - SPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top_r <= result;
    end
  end

  // Output register: load the finished result, drop it once transferred
  assign top_show = (sp_r != '0) ? top_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_top_r    <= sbe_pkg::TOP_W'(signed'(top_show));
      out_depth_r  <= sp_r;
      out_status_r <= status_r;
      out_done_r   <= (func_r == sbe_pkg::FN_RET);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;
  assign out_status    = out_status_r;
  assign out_done_res  = out_done_r;

  // Status toward the controller
  assign sts.fault     = (status_r != sbe_pkg::ST_OK);
  assign sts.op_direct = (func_r == sbe_pkg::FN_ADD) || (func_r == sbe_pkg::FN_SUB) ||
                         (func_r == sbe_pkg::FN_PUSH);
  assign sts.op_iter   = (func_r == sbe_pkg::FN_MUL) || (func_r == sbe_pkg::FN_DIV);
  assign sts.iter_last = (cnt_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> status_r == sbe_pkg::ST_OK)
    else $error("stack written by a faulted item");

  a_commit_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> sp_r != $past(sp_r))
    else $error("commit left the stack pointer unchanged");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten before transfer");

  a_iter_op: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_iter |-> (func_r == sbe_pkg::FN_MUL || func_r == sbe_pkg::FN_DIV))
    else $error("iterative unit started for a direct operation");

endmodule

FILE: rtl/stack_bytecode_executor.sv
// Stack bytecode executor.
// Input channel (in_valid / in_stall): one instruction per transfer, in_func
// selects add, sub, mul, div, push or return; in_push_value is the constant
// used by push. Result channel (out_valid / out_stall): one result per
// instruction with the top entry (zero when empty), depth, status and a done
// flag set for return. Faulted items (underflow, overflow, divide by zero)
// leave the stack untouched.
// Push, add and sub pass the decode, write and output states before the next
// transfer is accepted; mul and div also pass the iterative state of the
// shared shift-add / restoring divide unit, which retires one bit per cycle;
// return, unused codes and faults go from decode to output. The result is
// registered and shows on out_valid when the item leaves the sequencer.
// The output register lets the next instruction be accepted while a result
// still waits; if the receiver keeps out_stall high, the following result
// holds inside the block and in_stall stays high until the register frees.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result; stack memory contents are not cleared.
module stack_bytecode_executor #(
  parameter int STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = sbe_pkg::DATA_WIDTH_DEF,
  localparam int SPW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sbe_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [sbe_pkg::PUSH_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sbe_pkg::TOP_W-1:0]  out_top_value,
  output logic [SPW-1:0]                    out_depth,
  output logic [sbe_pkg::STATUS_W-1:0]      out_status,
  output logic                              out_done_res
);

  sbe_pkg::cmd_t cmd;
  sbe_pkg::sts_t sts;

  sbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbe_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_func),
    .in_push_value (in_push_value),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_top_value (out_top_value),
    .out_depth     (out_depth),
    .out_status    (out_status),
    .out_done_res  (out_done_res)
  );

endmodule
